FILE: src/lips_pkg.sv
// Package for the learned-index predecessor search unit.
// Holds field widths, op and register codes, shared types and the controller states.
// No dependencies.
package lips_pkg;

  localparam int KEY_W  = 32;
  localparam int SLOT_W = 16;
  localparam int OP_W   = 2;
  localparam int SEGC_W = 5;
  localparam int KEYC_W = 16;
  localparam int OFS_W  = 31;
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam int POS_W  = 50;

  localparam logic [OP_W-1:0] OP_LOAD_SEG = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_KEY = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

  localparam logic [1:0] REG_SEG_COUNT  = 2'd0;
  localparam logic [1:0] REG_KEY_COUNT  = 2'd1;
  localparam logic [1:0] REG_POS_OFFSET = 2'd2;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [SEGC_W-1:0] seg_count;
    logic [KEYC_W-1:0] key_count;
    logic [OFS_W-1:0]  pos_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] first_key;
    logic signed [KEY_W-1:0] slope;
    logic signed [KEY_W-1:0] intercept;
  } seg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_MUL,
    ST_ADD,
    ST_OFS,
    ST_WIN,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

FILE: src/learned_index_predecessor_search_unit.sv
// Learned-index predecessor search unit. Load beats write one segment (first key, Q16.16
// slope, intercept) or one sorted key. A query reads the segment memory one entry a cycle
// from slot 1 until a segment's first key exceeds the query key (at most segment_count + 1
// reads), then computes the product, the clamped position, the offset and the window
// bounds in turn, then reads the key memory one entry a cycle over at most 2*ERROR_BOUND+3
// entries, and loads the result register once the output is free. One item is in work at
// a time; the result register lets the next beat in while a result waits. Neither memory
// is cleared after reset.
module learned_index_predecessor_search_unit
  import lips_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16,
  parameter int KEY_DEPTH    = 65536,
  parameter int ERROR_BOUND  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_op,
  input  logic [SLOT_W-1:0]        in_slot,
  input  logic signed [KEY_W-1:0]  in_key_value,
  input  logic signed [KEY_W-1:0]  in_slope,
  input  logic signed [KEY_W-1:0]  in_intercept,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_found,
  output logic signed [KEY_W-1:0]  out_predecessor_key,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int SEG_DEPTH = MAX_SEGMENTS + 2;
  localparam int SW        = $clog2(SEG_DEPTH);
  localparam int KAW       = $clog2(KEY_DEPTH);
  localparam int KLIM      = (KEY_DEPTH > 2**KEYC_W) ? 2**KEYC_W - 1 : KEY_DEPTH - 1;
  localparam logic [KEYC_W-1:0] KLAST = KEYC_W'(KLIM);
  localparam logic [POS_W-1:0]  EB    = POS_W'(ERROR_BOUND);
  localparam logic [POS_W-1:0]  EB2   = POS_W'(ERROR_BOUND + 2);

  cfg_t cfg;

  lips_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t state_r, state_nxt;

  logic in_acc;
  logic seg_we, key_we;
  logic [SW-1:0]  seg_waddr, seg_raddr;
  logic [KAW-1:0] key_waddr, key_raddr;
  seg_t seg_wdata, seg_rdata;
  logic [KEY_W-1:0] key_rdata;
  logic [KAW+SLOT_W-1:0] slot_ext, scan_ext;

  logic signed [KEY_W-1:0] qkey_r;
  logic [SW-1:0]  cnt_r, iss_idx_r, chk_idx_r;
  logic [31:0]    cnt_wide;
  logic           chk_vld_r, sel_vld_r;
  seg_t           cur_r;
  logic signed [KEY_W-1:0] nxt_int_r;
  logic signed [64:0] prod_r, prod_nxt;
  logic signed [KEY_W:0] key_diff;
  logic signed [POS_W-1:0] q_sum;
  logic [POS_W-1:0] pos_r, pos_clamp, pos_nxt, ofs_nxt, lo_w, hi_w;
  logic [KEYC_W-1:0] hi_c, end_w;
  logic              empty_w;
  logic [KEYC_W-1:0] iss_n_r, chk_n_r, end_r;
  logic              have_r;
  logic signed [KEY_W-1:0] prev_r;
  logic              out_valid_r, out_found_r;
  logic signed [KEY_W-1:0] out_pred_r;

  logic seg_pass, seg_stop;
  logic scan_eq, scan_gt, scan_stop;
  logic out_free, out_load;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Memories
  assign seg_we    = in_acc && (in_op == OP_LOAD_SEG) && (32'(in_slot) < 32'(SEG_DEPTH));
  assign seg_waddr = in_slot[SW-1:0];
  assign seg_wdata = '{first_key: in_key_value, slope: in_slope, intercept: in_intercept};
  assign seg_raddr = iss_idx_r;

  assign slot_ext  = {{KAW{1'b0}}, in_slot};
  assign scan_ext  = {{KAW{1'b0}}, iss_n_r};
  assign key_we    = in_acc && (in_op == OP_LOAD_KEY) && (in_slot <= KLAST);
  assign key_waddr = slot_ext[KAW-1:0];
  assign key_raddr = scan_ext[KAW-1:0];

  lips_ram #(.WIDTH($bits(seg_t)), .DEPTH(SEG_DEPTH)) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (seg_wdata),
    .raddr (seg_raddr),
    .rdata (seg_rdata)
  );

  lips_ram #(.WIDTH(KEY_W), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_key_value),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // Segment walk and key scan decisions
  assign seg_pass  = (chk_idx_r <= cnt_r) && (seg_rdata.first_key <= qkey_r);
  assign seg_stop  = chk_vld_r && !seg_pass;
  assign scan_eq   = $signed(key_rdata) == qkey_r;
  assign scan_gt   = $signed(key_rdata) > qkey_r;
  assign scan_stop = chk_vld_r && (scan_eq || scan_gt || (chk_n_r == end_r));

  // Prediction arithmetic
  assign cnt_wide = (32'(cfg.seg_count) > 32'(MAX_SEGMENTS)) ? 32'(MAX_SEGMENTS)
                                                             : 32'(cfg.seg_count);
  assign key_diff = {qkey_r[KEY_W-1], qkey_r} - {cur_r.first_key[KEY_W-1], cur_r.first_key};
  assign prod_nxt = cur_r.slope * key_diff;
  assign q_sum    = {prod_r[64], prod_r[64:16]}
                  + {{(POS_W-KEY_W){cur_r.intercept[KEY_W-1]}}, cur_r.intercept};
  assign pos_clamp = q_sum[POS_W-1] ? '0 : q_sum;
  assign pos_nxt   = (!nxt_int_r[KEY_W-1] &&
                      pos_clamp > {{(POS_W-KEY_W){1'b0}}, nxt_int_r})
                   ? {{(POS_W-KEY_W){1'b0}}, nxt_int_r} : pos_clamp;
  assign ofs_nxt   = (pos_r > {{(POS_W-OFS_W){1'b0}}, cfg.pos_offset})
                   ? pos_r - {{(POS_W-OFS_W){1'b0}}, cfg.pos_offset} : '0;
  assign lo_w      = (pos_r <= EB) ? '0 : pos_r - EB;
  assign hi_w      = pos_r + EB2;
  assign hi_c      = (hi_w >= {{(POS_W-KEYC_W){1'b0}}, cfg.key_count})
                   ? cfg.key_count : hi_w[KEYC_W-1:0];
  assign end_w     = (hi_c < KLAST) ? hi_c : KLAST;
  assign empty_w   = ((lo_w == '0) && (hi_c == '0))
                   || (lo_w > {{(POS_W-KEYC_W){1'b0}}, end_w});

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_QUERY)) begin
          state_nxt = ST_SEG;
        end
      end
      ST_SEG: begin
        if (seg_stop) begin
          state_nxt = sel_vld_r ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_OFS;
      ST_OFS:  state_nxt = ST_WIN;
      ST_WIN:  state_nxt = empty_w ? ST_FIN : ST_SCAN;
      ST_SCAN: begin
        if (scan_stop) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_FIN:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_SEG || state_r == ST_SCAN) begin
        chk_vld_r <= 1'b1;
      end else begin
        chk_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        qkey_r    <= in_key_value;
        cnt_r     <= cnt_wide[SW-1:0];
        iss_idx_r <= SW'(1);
        sel_vld_r <= 1'b0;
        have_r    <= 1'b0;
        prev_r    <= KEY_MIN;
      end
      ST_SEG: begin
        chk_idx_r <= iss_idx_r;
        if (iss_idx_r <= cnt_r) begin
          iss_idx_r <= iss_idx_r + SW'(1);
        end
        if (chk_vld_r) begin
          if (seg_pass) begin
            cur_r     <= seg_rdata;
            sel_vld_r <= 1'b1;
          end else begin
            nxt_int_r <= seg_rdata.intercept;
          end
        end
      end
      ST_MUL:  prod_r <= prod_nxt;
      ST_ADD:  pos_r  <= pos_nxt;
      ST_OFS:  pos_r  <= ofs_nxt;
      ST_WIN: begin
        iss_n_r <= lo_w[KEYC_W-1:0];
        end_r   <= end_w;
      end
      ST_SCAN: begin
        chk_n_r <= iss_n_r;
        if (iss_n_r < end_r) begin
          iss_n_r <= iss_n_r + KEYC_W'(1);
        end
        if (chk_vld_r && !scan_gt) begin
          prev_r <= scan_eq ? qkey_r : $signed(key_rdata);
          have_r <= 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_found_r <= have_r;
      out_pred_r  <= prev_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_predecessor_key = out_pred_r;

endmodule

FILE: src/lips_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lips_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/lips_cfg.sv
// APB register file of the predecessor search unit: segment count, key count, offset.
// Depends on lips_pkg.
module lips_cfg
  import lips_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SEG_COUNT:  cfg_r.seg_count  <= pwdata[SEGC_W-1:0];
        REG_KEY_COUNT:  cfg_r.key_count  <= pwdata[KEYC_W-1:0];
        REG_POS_OFFSET: cfg_r.pos_offset <= pwdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SEG_COUNT:  prdata = {{(APB_DW-SEGC_W){1'b0}}, cfg_r.seg_count};
      REG_KEY_COUNT:  prdata = {{(APB_DW-KEYC_W){1'b0}}, cfg_r.key_count};
      REG_POS_OFFSET: prdata = {{(APB_DW-OFS_W){1'b0}}, cfg_r.pos_offset};
      default:        prdata = '0;
    endcase
  end

endmodule
